@@ rtl/fqrr_pkg.sv @@
package fqrr_pkg;

    // Fixed field widths of the command and result transactions.
    localparam int MODE_W     = 2;
    localparam int QIDX_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FIELD_ID_W = 16;
    localparam int NUM_QUEUES = 4;

    // Command modes.
    localparam logic [MODE_W-1:0] MODE_SELECT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SERVE   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [QIDX_W-1:0]     direction;
        logic [FIELD_ID_W-1:0] item_id;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [FIELD_ID_W-1:0] served_id;
        logic [QIDX_W-1:0]     served_queue;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } ctrl_t;

endpackage

@@ rtl/fqrr_ram.sv @@
module fqrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/fqrr_ctrl.sv @@
module fqrr_ctrl
    import fqrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_stall,
    output logic  res_valid,
    input  logic  res_stall,
    output ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   cmd_stall_reg, cmd_stall_next;
    logic   res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd_stall_next = cmd_stall_reg;
        res_valid_next = res_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next     = S_EXEC;
                    cmd_stall_next = 1'b1;
                end
            end
            S_EXEC:
            begin
                state_next     = S_RESP;
                res_valid_next = 1'b1;
            end
            S_RESP:
            begin
                if (!res_stall)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b0;
                    cmd_stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                cmd_stall_next = 1'b0;
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_stall_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_stall_reg <= cmd_stall_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_stall    = cmd_stall_reg;
    assign res_valid    = res_valid_reg;
    assign ctrl.capture = (state_reg == S_IDLE) && cmd_valid;
    assign ctrl.exec    = (state_reg == S_EXEC);

endmodule

@@ rtl/fqrr_datapath.sv @@
module fqrr_datapath
    import fqrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  cmd_t  cmd,
    output res_t  res
);

    localparam int STORE_W  = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W   = QIDX_W + PTR_W;
    localparam int RAM_SIZE = NUM_QUEUES * (1 << PTR_W);

    cmd_t                cmd_reg, cmd_next;
    logic [PTR_W-1:0]    rd_ptr_reg [NUM_QUEUES];
    logic [PTR_W-1:0]    rd_ptr_next [NUM_QUEUES];
    logic [CNT_W-1:0]    count_reg [NUM_QUEUES];
    logic [CNT_W-1:0]    count_next [NUM_QUEUES];
    logic [QIDX_W-1:0]   cur_dir_reg, cur_dir_next;
    logic                chosen_reg, chosen_next;
    logic [QIDX_W-1:0]   next_q_reg, next_q_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [QIDX_W-1:0]   queue_reg, queue_next;

    logic                found;
    logic [QIDX_W-1:0]   pick;
    logic [QIDX_W-1:0]   probe;
    logic [PTR_W:0]      slot_sum;
    logic [PTR_W-1:0]    slot;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [STORE_W-1:0]  rd_data;

    // Round-robin search starting at the queue after the last one served.
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        probe = '0;
        for (int k = 0; k < NUM_QUEUES; k++)
        begin
            probe = next_q_reg + QIDX_W'(k);
            if (!found && (count_reg[probe] != '0))
            begin
                found = 1'b1;
                pick  = probe;
            end
        end
    end

    // Tail slot of the current queue, wrapped into the ring.
    always_comb
    begin
        slot_sum = (PTR_W + 1)'(rd_ptr_reg[cur_dir_reg]) + (PTR_W + 1)'(count_reg[cur_dir_reg]);
        if (slot_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
        begin
            slot = PTR_W'(slot_sum - (PTR_W + 1)'(QUEUE_DEPTH));
        end
        else
        begin
            slot = PTR_W'(slot_sum);
        end
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        cur_dir_next = cur_dir_reg;
        chosen_next  = chosen_reg;
        next_q_next  = next_q_reg;
        status_next  = status_reg;
        queue_next   = queue_reg;
        wr_en        = 1'b0;
        wr_addr      = {cur_dir_reg, slot};
        rd_en        = 1'b0;
        rd_addr      = {pick, rd_ptr_reg[pick]};

        if (ctrl.capture)
        begin
            cmd_next = cmd;
        end

        if (ctrl.exec)
        begin
            queue_next = '0;
            case (cmd_reg.mode)
                MODE_SELECT:
                begin
                    cur_dir_next = cmd_reg.direction;
                    chosen_next  = 1'b1;
                    status_next  = ST_ACCEPTED;
                end
                MODE_ENQUEUE:
                begin
                    if (!chosen_reg || (count_reg[cur_dir_reg] == CNT_W'(QUEUE_DEPTH)))
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        wr_en                   = 1'b1;
                        count_next[cur_dir_reg] = count_reg[cur_dir_reg] + CNT_W'(1);
                        status_next             = ST_ACCEPTED;
                    end
                end
                MODE_SERVE:
                begin
                    if (found)
                    begin
                        rd_en = 1'b1;
                        if (rd_ptr_reg[pick] == PTR_W'(QUEUE_DEPTH - 1))
                        begin
                            rd_ptr_next[pick] = '0;
                        end
                        else
                        begin
                            rd_ptr_next[pick] = rd_ptr_reg[pick] + PTR_W'(1);
                        end
                        count_next[pick] = count_reg[pick] - CNT_W'(1);
                        next_q_next      = pick + QIDX_W'(1);
                        status_next      = ST_SERVED;
                        queue_next       = pick;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    status_next = ST_DROPPED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                rd_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
            cur_dir_reg <= '0;
            chosen_reg  <= 1'b0;
            next_q_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            cur_dir_reg <= cur_dir_next;
            chosen_reg  <= chosen_next;
            next_q_reg  <= next_q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        queue_reg  <= queue_next;
    end

    fqrr_ram #(
        .WIDTH (STORE_W),
        .DEPTH (RAM_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd_reg.item_id[STORE_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The store's read register holds until the next serve, so it feeds the
    // result directly while the result waits.
    assign res.status       = status_reg;
    assign res.served_id    = (status_reg == ST_SERVED) ? FIELD_ID_W'(rd_data) : '0;
    assign res.served_queue = queue_reg;

endmodule

@@ rtl/four_queue_round_robin_server_top.sv @@
// Four-queue round-robin server. The block keeps four FIFO queues of
// identifiers (0 west, 1 north, 2 south, 3 east), each QUEUE_DEPTH deep, in
// one shared memory. A select transaction sets the current direction, an
// enqueue transaction appends its identifier to the queue of that direction
// (it is dropped if no direction was ever selected or the queue is full), and
// a serve transaction pops one identifier, searching from the queue after the
// one last served and skipping empty queues. Every command transaction yields
// exactly one result transaction. Commands are handled one at a time: a
// command is taken, executed in the next cycle (queue update and the memory
// read of the served entry), and its result is then offered from the
// registered read of the shared queue memory and the result holding
// registers until the result side takes it. cmd_stall stays high from the
// cycle after a command is taken until its result has been taken.
// Identifiers are stored in the low ID_WIDTH bits (at most 16); served_id
// is zero unless the status says an identifier was served.
module four_queue_round_robin_server_top
    import fqrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    // Command strobes from the sequencer to the queue datapath.
    ctrl_t ctrl;

    fqrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctrl      (ctrl)
    );

    // The datapath holds the queue pointers, occupancy counts, direction and
    // round-robin state, and the shared identifier memory.
    fqrr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cmd   (cmd),
        .res   (res)
    );

endmodule

@@ rtl/fqrr_checker.sv @@
module fqrr_checker
    import fqrr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    // A result waiting on a stall keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Only one command is in flight, so no command is taken while a result waits.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall)
        else $error("command side open while a result is pending");

    // A taken command is executed before its result appears.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall && !res_valid)
        else $error("no execute cycle after a command");

    // Identifier and queue fields are zero unless an identifier was served.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status != ST_SERVED) |->
            (res.served_id == '0) && (res.served_queue == '0))
        else $error("nonzero served fields without a served identifier");

endmodule

bind four_queue_round_robin_server_top fqrr_checker u_fqrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
